// File: design/mse_pkg.sv
package mse_pkg;
  localparam int MaxKeys  = 64;
  localparam int KeyWidth = 64;
  localparam int IdxW     = $clog2(MaxKeys);
  localparam int CntW     = $clog2(MaxKeys + 1);

  // Front-to-back queue entry: one input item.
  typedef struct packed {
    logic [KeyWidth-1:0] key;
    logic                last;
  } item_t;

  localparam int QDepth = 2;
endpackage

// File: design/mse_ram.sv
module mse_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/mse_front.sv
module mse_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          in_key,
  input  logic                 in_last,
  output logic                 q_valid,
  input  logic                 q_ready,
  output mse_pkg::item_t       q_item
);
  localparam int PW = $clog2(mse_pkg::QDepth);

  mse_pkg::item_t  buffer [mse_pkg::QDepth];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;
  logic            push;
  logic            pop;

  assign in_ready = (fill != PW'(0) + (PW+1)'(mse_pkg::QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = buffer[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        buffer[wr_ptr].key  <= in_key[mse_pkg::KeyWidth-1:0];
        buffer[wr_ptr].last <= in_last;
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PW+1)'(mse_pkg::QDepth)) else $error("queue overfilled");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    fill == (PW+1)'(mse_pkg::QDepth) |-> !push) else $error("push when full");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + (PW+1)'(1)) else $error("fill count slip");
endmodule

// File: design/mse_back.sv
module mse_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  mse_pkg::item_t                 q_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mse_pkg::KeyWidth-1:0]   out_key,
  output logic                           out_last,
  output logic                           out_ovf
);
  localparam int IW = mse_pkg::IdxW;
  localparam int CW = mse_pkg::CntW;
  localparam int KW = mse_pkg::KeyWidth;

  typedef enum logic [2:0] {
    S_LOAD, S_COPY, S_MRD, S_MCMP, S_EMIT_RD, S_EMIT_WAIT, S_EMIT
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic          dropped;
  // Bottom-up passes; a stable merge gives the same order as a top-down split.
  logic [CW:0]   width;
  logic [CW:0]   mid;
  logic [CW:0]   hi;
  logic [CW:0]   ii;
  logic [CW:0]   jj;
  logic [CW:0]   kk;
  logic [KW-1:0] key_i;
  logic [KW-1:0] key_j;
  logic          sel_j;

  // key RAM
  logic          k_we;
  logic [IW-1:0] k_waddr;
  logic [KW-1:0] k_wdata;
  logic [IW-1:0] k_raddr;
  logic [KW-1:0] k_rdata;
  // scratch RAMs: two copies so both heads can be read in the same cycle
  logic          s_we;
  logic [IW-1:0] s_waddr;
  logic [IW-1:0] s_raddr_a;
  logic [IW-1:0] s_raddr_b;
  logic [KW-1:0] s_rdata_a;
  logic [KW-1:0] s_rdata_b;
  logic [CW:0]   copy_rd;

  mse_ram #(.Width(KW), .Depth(mse_pkg::MaxKeys)) u_key (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata));
  mse_ram #(.Width(KW), .Depth(mse_pkg::MaxKeys)) u_scr_a (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(k_rdata), .raddr(s_raddr_a), .rdata(s_rdata_a));
  mse_ram #(.Width(KW), .Depth(mse_pkg::MaxKeys)) u_scr_b (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(k_rdata), .raddr(s_raddr_b), .rdata(s_rdata_b));

  logic [CW:0] cnt_x;
  assign cnt_x = {1'b0, count};

  assign q_ready   = (state == S_LOAD);
  assign out_valid = (state == S_EMIT);

  // Heads: when a run is exhausted the other is chosen regardless.
  always_comb begin
    key_i = s_rdata_a;
    key_j = s_rdata_b;
    if (ii >= mid) begin
      sel_j = 1'b1;
    end else if (jj >= hi) begin
      sel_j = 1'b0;
    end else begin
      sel_j = (key_j < key_i);
    end
  end

  always_comb begin
    k_we      = 1'b0;
    k_waddr   = kk[IW-1:0];
    k_wdata   = sel_j ? key_j : key_i;
    k_raddr   = copy_rd[IW-1:0];
    s_raddr_a = ii[IW-1:0];
    s_raddr_b = jj[IW-1:0];
    case (state)
      S_LOAD: begin
        k_we    = q_valid && (count != CW'(mse_pkg::MaxKeys));
        k_waddr = count[IW-1:0];
        k_wdata = q_item.key;
      end
      S_MCMP: begin
        k_we = 1'b1;
      end
      S_EMIT_RD, S_EMIT_WAIT, S_EMIT: begin
        k_raddr = kk[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  logic [CW:0] ii_n;
  logic [CW:0] jj_n;
  always_comb begin
    ii_n = sel_j ? ii : ii + (CW+1)'(1);
    jj_n = sel_j ? jj + (CW+1)'(1) : jj;
  end

  function automatic logic [CW:0] min_c(input logic [CW:0] a, input logic [CW:0] b);
    min_c = (a < b) ? a : b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      dropped <= 1'b0;
      s_we    <= 1'b0;
      width   <= '0;
      mid     <= '0;
      hi      <= '0;
      ii      <= '0;
      jj      <= '0;
      kk      <= '0;
      copy_rd <= '0;
      out_key <= '0;
      out_last <= 1'b0;
      out_ovf <= 1'b0;
    end else begin
      s_we <= 1'b0;
      case (state)
        S_LOAD: begin
          if (q_valid) begin
            logic [CW-1:0] nc;
            nc = (count != CW'(mse_pkg::MaxKeys)) ? count + CW'(1) : count;
            count <= nc;
            if (count == CW'(mse_pkg::MaxKeys)) begin
              dropped <= 1'b1;
            end
            if (q_item.last) begin
              width <= (CW+1)'(1);
              copy_rd <= '0;
              kk <= '0;
              state <= (nc > CW'(1)) ? S_COPY : S_EMIT_RD;
            end
          end
        end
        S_COPY: begin
          // Copy key store into scratch: read addr copy_rd, write it in the next cycle.
          s_waddr <= copy_rd[IW-1:0];
          if (copy_rd < cnt_x) begin
            s_we <= 1'b1;
            copy_rd <= copy_rd + (CW+1)'(1);
          end else begin
            mid   <= min_c(width, cnt_x);
            hi    <= min_c(width << 1, cnt_x);
            ii    <= '0;
            jj    <= min_c(width, cnt_x);
            kk    <= '0;
            state <= S_MRD;
          end
        end
        S_MRD: begin
          state <= S_MCMP;
        end
        S_MCMP: begin
          kk <= kk + (CW+1)'(1);
          ii <= ii_n;
          jj <= jj_n;
          state <= S_MRD;
          if (kk + (CW+1)'(1) == hi) begin
            if (hi >= cnt_x) begin
              if ((width << 1) >= cnt_x) begin
                kk    <= '0;
                state <= S_EMIT_RD;
              end else begin
                width   <= width << 1;
                copy_rd <= '0;
                state   <= S_COPY;
              end
            end else begin
              mid <= min_c(hi + width, cnt_x);
              hi  <= min_c(hi + (width << 1), cnt_x);
              ii  <= hi;
              jj  <= min_c(hi + width, cnt_x);
            end
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          out_key  <= k_rdata;
          out_last <= (kk + (CW+1)'(1) == cnt_x);
          out_ovf  <= dropped;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            if (out_last) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= S_LOAD;
            end else begin
              kk    <= kk + (CW+1)'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(mse_pkg::MaxKeys)) else $error("count beyond capacity");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_key)) else $error("result dropped");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> count == '0 && !dropped) else $error("batch not cleared");
endmodule

// File: design/merge_sort_engine_core.sv
// Batch merge sorter.
// Input stream s_axis_*: tdata[63:0] holds one key; tlast marks the final key of a
// batch. Keys are loaded one per cycle while the sorter is in its load state,
// into a 64-entry store; keys beyond 64 are dropped and the batch is flagged.
// The tlast item starts the sort. Output stream m_axis_*: tdata[63:0] is the
// key, tlast marks the final sorted key, tuser[0] is the overflow flag, set on
// every result of a lossy batch.
// The sort is bottom-up stable merging through a scratch copy: each of the
// ceil(log2 n) passes first copies the n keys to scratch, then merges them;
// each merge step reads both run heads, then compares and writes one key back,
// since the reads are registered. Each sorted key is then emitted through a
// read state, a wait state and an emit state.
// A two-entry queue separates input acceptance from sorting, so input stalls
// only once that queue is full. When the receiver stalls, the current result
// holds and the sorter waits. Reset empties the queue and clears the batch.
module merge_sort_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key_in[63:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // key_out[63:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // overflow
);
  logic           q_valid;
  logic           q_ready;
  mse_pkg::item_t q_item;

  mse_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_key(s_axis_tdata), .in_last(s_axis_tlast),
    .q_valid, .q_ready, .q_item);

  mse_back u_back (
    .clk, .rst,
    .q_valid, .q_ready, .q_item,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_key(m_axis_tdata), .out_last(m_axis_tlast), .out_ovf(m_axis_tuser));
endmodule
